@@ rtl/fhtsp_pkg.sv @@
// Shared constants, codes and types of the file handle table and sector planner.
package fhtsp_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HANDLE_W   = 6;
    localparam int BYTE_W     = 31;
    localparam int SECTOR_W   = 32;
    localparam int OFFSET_W   = 11;
    localparam int COUNT_W    = 21;
    localparam int ENTRY_W    = 3 * BYTE_W;

    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_SEEK  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLOSE = 2'd3;

    localparam logic [1:0] ORG_SET = 2'd0;
    localparam logic [1:0] ORG_CUR = 2'd1;
    localparam logic [1:0] ORG_END = 2'd2;
    localparam logic [1:0] ORG_BAD = 2'd3;

    localparam logic [3:0] MODE_READ_ONLY = 4'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_BAD_MODE   = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_NOT_OPEN   = 3'd4;
    localparam logic [2:0] ST_BAD_ORIGIN = 3'd5;

    localparam logic [11:0] SECTOR_BYTES = 12'd2048;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_CALC   = 5'b00100,
        S_PLAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic calc_en;
        logic plan_en;
        logic finish_en;
    } cmd_t;

endpackage

@@ rtl/fhtsp_ram.sv @@
// Generic single write port RAM with one registered read port.
module fhtsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fhtsp_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module fhtsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output fhtsp_pkg::cmd_t  cmd
);

    fhtsp_pkg::state_t state_reg;
    fhtsp_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              load;

    assign in_ready = (state_reg == fhtsp_pkg::S_IDLE);
    assign load     = (state_reg == fhtsp_pkg::S_FINISH) && (!out_valid_reg || out_ready);

    assign cmd.latch_in  = in_valid && in_ready;
    assign cmd.calc_en   = (state_reg == fhtsp_pkg::S_CALC);
    assign cmd.plan_en   = (state_reg == fhtsp_pkg::S_PLAN);
    assign cmd.finish_en = load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fhtsp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fhtsp_pkg::S_FETCH;
                end
            end
            fhtsp_pkg::S_FETCH:  state_next = fhtsp_pkg::S_CALC;
            fhtsp_pkg::S_CALC:   state_next = fhtsp_pkg::S_PLAN;
            fhtsp_pkg::S_PLAN:   state_next = fhtsp_pkg::S_FINISH;
            fhtsp_pkg::S_FINISH:
            begin
                if (load)
                begin
                    state_next = fhtsp_pkg::S_IDLE;
                end
            end
            default:             state_next = fhtsp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fhtsp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/fhtsp_dp.sv @@
// Datapath: handle table, seek clamping, read grant and sector split, result register.
module fhtsp_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fhtsp_pkg::cmd_t                     cmd,
    input  logic [1:0]                          action,
    input  logic [fhtsp_pkg::HANDLE_W-1:0]      handle,
    input  logic                                file_found,
    input  logic [3:0]                          open_mode,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        file_length,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        start_lba,
    input  logic signed [31:0]                  seek_offset,
    input  logic [1:0]                          seek_origin,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        read_length,
    output logic [2:0]                          status,
    output logic [fhtsp_pkg::BYTE_W-1:0]        value,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      head_sector,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      head_offset,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      head_bytes,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      body_sector,
    output logic [fhtsp_pkg::COUNT_W-1:0]       body_sectors,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      tail_sector,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      tail_bytes
);

    localparam int BW = fhtsp_pkg::BYTE_W;
    localparam int SW = fhtsp_pkg::SECTOR_W;
    localparam int OW = fhtsp_pkg::OFFSET_W;
    localparam int CW = fhtsp_pkg::COUNT_W;
    localparam int LW = fhtsp_pkg::SLOT_W;

    // Captured request.
    logic [1:0]       act_reg;
    logic [5:0]       hdl_reg;
    logic             found_reg;
    logic [3:0]       mode_reg;
    logic [BW-1:0]    flen_reg;
    logic [BW-1:0]    slba_reg;
    logic [31:0]      soff_reg;
    logic [1:0]       sorg_reg;
    logic [BW-1:0]    rlen_reg;

    logic [fhtsp_pkg::SLOT_COUNT-1:0] used_reg;
    logic [fhtsp_pkg::SLOT_COUNT-1:0] used_next;

    logic [LW-1:0]    hdl_idx;
    logic [fhtsp_pkg::ENTRY_W-1:0] ent_rd;
    logic [BW-1:0]    ent_len;
    logic [BW-1:0]    ent_lba;
    logic [BW-1:0]    ent_pos;

    logic             ram_we;
    logic [LW-1:0]    ram_waddr;
    logic [fhtsp_pkg::ENTRY_W-1:0] ram_wdata;

    // Evaluation stage.
    logic             in_range;
    logic             hdl_open;
    logic             free_found;
    logic [LW-1:0]    free_idx;
    logic [2:0]       status_c;
    logic [BW-1:0]    seek_base;
    logic [33:0]      seek_sum;
    logic [BW-1:0]    seek_pos;
    logic [BW-1:0]    remain;
    logic [BW-1:0]    grant_c;

    logic [2:0]       status_reg;
    logic [LW-1:0]    slot_reg;
    logic [BW-1:0]    grant_reg;
    logic [BW-1:0]    newpos_reg;

    // Split stage.
    logic [SW-1:0]    hsec_c;
    logic [OW-1:0]    hoff_c;
    logic [11:0]      hgap;
    logic [OW-1:0]    hbytes_c;
    logic [SW-1:0]    hsec_reg;
    logic [OW-1:0]    hoff_reg;
    logic [OW-1:0]    hbytes_reg;
    logic [BW-1:0]    rest_reg;

    // Final stage.
    logic             bump;
    logic [SW-1:0]    bsec_c;
    logic [CW-1:0]    bcount_c;
    logic [SW-1:0]    tsec_c;
    logic             is_ok;
    logic             rd_ok;
    logic [BW-1:0]    value_c;

    logic [2:0]       status_o_reg;
    logic [BW-1:0]    value_o_reg;
    logic [SW-1:0]    hsec_o_reg;
    logic [OW-1:0]    hoff_o_reg;
    logic [OW-1:0]    hbytes_o_reg;
    logic [SW-1:0]    bsec_o_reg;
    logic [CW-1:0]    bcount_o_reg;
    logic [SW-1:0]    tsec_o_reg;
    logic [OW-1:0]    tbytes_o_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg   <= action;
            hdl_reg   <= handle;
            found_reg <= file_found;
            mode_reg  <= open_mode;
            flen_reg  <= file_length;
            slba_reg  <= start_lba;
            soff_reg  <= seek_offset;
            sorg_reg  <= seek_origin;
            rlen_reg  <= read_length;
        end
    end

    assign hdl_idx = hdl_reg[LW-1:0];

    fhtsp_ram #(
        .WIDTH (fhtsp_pkg::ENTRY_W),
        .DEPTH (fhtsp_pkg::SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (hdl_idx),
        .rdata (ent_rd)
    );

    assign ent_len = ent_rd[3*BW-1:2*BW];
    assign ent_lba = ent_rd[2*BW-1:BW];
    assign ent_pos = ent_rd[BW-1:0];

    assign in_range = {1'b0, hdl_reg} < 7'(fhtsp_pkg::SLOT_COUNT);
    assign hdl_open = in_range && used_reg[hdl_idx];

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = fhtsp_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = LW'(i);
            end
        end
    end

    always_comb
    begin
        status_c = fhtsp_pkg::ST_OK;
        case (act_reg)
            fhtsp_pkg::ACT_OPEN:
            begin
                if (!found_reg)
                begin
                    status_c = fhtsp_pkg::ST_NOT_FOUND;
                end
                else if (mode_reg != fhtsp_pkg::MODE_READ_ONLY)
                begin
                    status_c = fhtsp_pkg::ST_BAD_MODE;
                end
                else if (!free_found)
                begin
                    status_c = fhtsp_pkg::ST_FULL;
                end
            end
            default:
            begin
                if (!hdl_open)
                begin
                    status_c = fhtsp_pkg::ST_NOT_OPEN;
                end
                else if (act_reg == fhtsp_pkg::ACT_SEEK && sorg_reg == fhtsp_pkg::ORG_BAD)
                begin
                    status_c = fhtsp_pkg::ST_BAD_ORIGIN;
                end
            end
        endcase
    end

    always_comb
    begin
        case (sorg_reg)
            fhtsp_pkg::ORG_CUR: seek_base = ent_pos;
            fhtsp_pkg::ORG_END: seek_base = ent_len;
            default:            seek_base = '0;
        endcase
    end

    assign seek_sum = {3'b000, seek_base} + {{2{soff_reg[31]}}, soff_reg};

    always_comb
    begin
        if (seek_sum[33])
        begin
            seek_pos = '0;
        end
        else if (seek_sum > {3'b000, ent_len})
        begin
            seek_pos = ent_len;
        end
        else
        begin
            seek_pos = seek_sum[BW-1:0];
        end
    end

    assign remain  = (ent_pos > ent_len) ? '0 : (ent_len - ent_pos);
    assign grant_c = (rlen_reg < remain) ? rlen_reg : remain;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_en)
        begin
            status_reg <= status_c;
            slot_reg   <= free_idx;
            grant_reg  <= grant_c;
            newpos_reg <= seek_pos;
        end
        else if (cmd.plan_en && act_reg == fhtsp_pkg::ACT_READ)
        begin
            newpos_reg <= ent_pos + grant_reg;
        end
    end

    assign hsec_c = {1'b0, ent_lba} + {12'b0, ent_pos[BW-1:OW]};
    assign hoff_c = ent_pos[OW-1:0];
    assign hgap   = fhtsp_pkg::SECTOR_BYTES - {1'b0, hoff_c};

    always_comb
    begin
        if (hoff_c == '0)
        begin
            hbytes_c = '0;
        end
        else if ({19'b0, hgap} > grant_reg)
        begin
            hbytes_c = grant_reg[OW-1:0];
        end
        else
        begin
            hbytes_c = hgap[OW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan_en)
        begin
            hsec_reg   <= hsec_c;
            hoff_reg   <= hoff_c;
            hbytes_reg <= hbytes_c;
            rest_reg   <= grant_reg - {20'b0, hbytes_c};
        end
    end

    assign bump     = (hoff_reg != '0);
    assign bsec_c   = hsec_reg + SW'(bump);
    assign bcount_c = {1'b0, rest_reg[BW-1:OW]};
    assign tsec_c   = hsec_reg + {12'b0, rest_reg[BW-1:OW]} + SW'(bump);

    assign is_ok = (status_reg == fhtsp_pkg::ST_OK);
    assign rd_ok = is_ok && (act_reg == fhtsp_pkg::ACT_READ);

    always_comb
    begin
        value_c = '0;
        if (is_ok)
        begin
            case (act_reg)
                fhtsp_pkg::ACT_OPEN: value_c = BW'(slot_reg);
                fhtsp_pkg::ACT_SEEK: value_c = newpos_reg;
                fhtsp_pkg::ACT_READ: value_c = grant_reg;
                default:             value_c = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_en)
        begin
            status_o_reg <= status_reg;
            value_o_reg  <= value_c;
            hsec_o_reg   <= rd_ok ? hsec_reg : '0;
            hoff_o_reg   <= rd_ok ? hoff_reg : '0;
            hbytes_o_reg <= rd_ok ? hbytes_reg : '0;
            bsec_o_reg   <= rd_ok ? bsec_c : '0;
            bcount_o_reg <= rd_ok ? bcount_c : '0;
            tsec_o_reg   <= rd_ok ? tsec_c : '0;
            tbytes_o_reg <= rd_ok ? rest_reg[OW-1:0] : '0;
        end
    end

    assign ram_we    = cmd.finish_en && is_ok && (act_reg != fhtsp_pkg::ACT_CLOSE);
    assign ram_waddr = (act_reg == fhtsp_pkg::ACT_OPEN) ? slot_reg : hdl_idx;
    assign ram_wdata = (act_reg == fhtsp_pkg::ACT_OPEN) ? {flen_reg, slba_reg, {BW{1'b0}}}
                                                        : {ent_len, ent_lba, newpos_reg};

    always_comb
    begin
        used_next = used_reg;
        if (cmd.finish_en && is_ok)
        begin
            if (act_reg == fhtsp_pkg::ACT_OPEN)
            begin
                used_next[slot_reg] = 1'b1;
            end
            else if (act_reg == fhtsp_pkg::ACT_CLOSE)
            begin
                used_next[hdl_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign status       = status_o_reg;
    assign value        = value_o_reg;
    assign head_sector  = hsec_o_reg;
    assign head_offset  = hoff_o_reg;
    assign head_bytes   = hbytes_o_reg;
    assign body_sector  = bsec_o_reg;
    assign body_sectors = bcount_o_reg;
    assign tail_sector  = tsec_o_reg;
    assign tail_bytes   = tbytes_o_reg;

endmodule

@@ rtl/file_handle_table_sector_planner_unit.sv @@
// Top level of the file handle table and sector planner.
//
// One request beat enters on the in channel (in_valid/in_ready) and exactly one
// result beat leaves on the out channel (out_valid/out_ready) for it.
// A request carries an action (open, seek, read, close) and its operands.
// Open claims the lowest free slot, seek clamps the new position to the file,
// and read grants the bytes asked for, up to the bytes left, and splits them into head, body and tail sectors.
// The block works on one request at a time: after a beat is accepted, in_ready
// stays low while the table entry is fetched from the slot RAM (one registered
// read), the grant and sector split are computed in two steps, and the result is
// loaded into the output register; a new request can be accepted in the cycle
// after the result is loaded.
// The output register holds its beat while the receiver stalls; the next request
// is still accepted and computed, and waits in its last step until the beat is taken.
// Reset clears all used marks, so every slot is free and reads as not open;
// slot contents are written by open before they are ever read.
module file_handle_table_sector_planner_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic [fhtsp_pkg::HANDLE_W-1:0]      handle,
    input  logic                                file_found,
    input  logic [3:0]                          open_mode,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        file_length,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        start_lba,
    input  logic signed [31:0]                  seek_offset,
    input  logic [1:0]                          seek_origin,
    input  logic [fhtsp_pkg::BYTE_W-1:0]        read_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status,
    output logic [fhtsp_pkg::BYTE_W-1:0]        value,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      head_sector,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      head_offset,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      head_bytes,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      body_sector,
    output logic [fhtsp_pkg::COUNT_W-1:0]       body_sectors,
    output logic [fhtsp_pkg::SECTOR_W-1:0]      tail_sector,
    output logic [fhtsp_pkg::OFFSET_W-1:0]      tail_bytes
);

    fhtsp_pkg::cmd_t cmd;

    fhtsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fhtsp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .handle       (handle),
        .file_found   (file_found),
        .open_mode    (open_mode),
        .file_length  (file_length),
        .start_lba    (start_lba),
        .seek_offset  (seek_offset),
        .seek_origin  (seek_origin),
        .read_length  (read_length),
        .status       (status),
        .value        (value),
        .head_sector  (head_sector),
        .head_offset  (head_offset),
        .head_bytes   (head_bytes),
        .body_sector  (body_sector),
        .body_sectors (body_sectors),
        .tail_sector  (tail_sector),
        .tail_bytes   (tail_bytes)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a request is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= fhtsp_pkg::ST_BAD_ORIGIN))
        else $error("result status out of range");

    a_body_follows_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (body_sector == head_sector + 32'(head_offset != '0)))
        else $error("body sector does not follow the head sector");

    a_tail_follows_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tail_sector == body_sector + 32'(body_sectors)))
        else $error("tail sector does not follow the body sectors");
`endif

endmodule

@@ tb/sv/file_handle_table_sector_planner_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the file handle table and sector planner unit.
module file_handle_table_sector_planner_unit_tb;

    localparam int SECTOR_SHIFT = 11;
    localparam int MAX_GAP      = 18;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [1:0]                     action;
        logic [fhtsp_pkg::HANDLE_W-1:0] handle;
        logic                           found;
        logic [3:0]                     mode;
        logic [fhtsp_pkg::BYTE_W-1:0]   length;
        logic [fhtsp_pkg::BYTE_W-1:0]   lba;
        logic signed [31:0]             offset;
        logic [1:0]                     origin;
        logic [fhtsp_pkg::BYTE_W-1:0]   read_len;
    } request_t;

    typedef struct packed {
        logic [2:0]                     status;
        logic [fhtsp_pkg::BYTE_W-1:0]   value;
        logic [fhtsp_pkg::SECTOR_W-1:0] head_sector;
        logic [fhtsp_pkg::OFFSET_W-1:0] head_offset;
        logic [fhtsp_pkg::OFFSET_W-1:0] head_bytes;
        logic [fhtsp_pkg::SECTOR_W-1:0] body_sector;
        logic [fhtsp_pkg::COUNT_W-1:0]  body_sectors;
        logic [fhtsp_pkg::SECTOR_W-1:0] tail_sector;
        logic [fhtsp_pkg::OFFSET_W-1:0] tail_bytes;
    } plan_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [1:0]                     action       = fhtsp_pkg::ACT_OPEN;
    logic [fhtsp_pkg::HANDLE_W-1:0] handle       = '0;
    logic                           file_found   = 1'b0;
    logic [3:0]                     open_mode    = '0;
    logic [fhtsp_pkg::BYTE_W-1:0]   file_length  = '0;
    logic [fhtsp_pkg::BYTE_W-1:0]   start_lba    = '0;
    logic signed [31:0]             seek_offset  = '0;
    logic [1:0]                     seek_origin  = fhtsp_pkg::ORG_SET;
    logic [fhtsp_pkg::BYTE_W-1:0]   read_length  = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic [2:0]                     status;
    logic [fhtsp_pkg::BYTE_W-1:0]   value;
    logic [fhtsp_pkg::SECTOR_W-1:0] head_sector;
    logic [fhtsp_pkg::OFFSET_W-1:0] head_offset;
    logic [fhtsp_pkg::OFFSET_W-1:0] head_bytes;
    logic [fhtsp_pkg::SECTOR_W-1:0] body_sector;
    logic [fhtsp_pkg::COUNT_W-1:0]  body_sectors;
    logic [fhtsp_pkg::SECTOR_W-1:0] tail_sector;
    logic [fhtsp_pkg::OFFSET_W-1:0] tail_bytes;

    bit                           tbl_used [fhtsp_pkg::SLOT_COUNT];
    logic [fhtsp_pkg::BYTE_W-1:0] tbl_len  [fhtsp_pkg::SLOT_COUNT];
    logic [fhtsp_pkg::BYTE_W-1:0] tbl_lba  [fhtsp_pkg::SLOT_COUNT];
    logic [fhtsp_pkg::BYTE_W-1:0] tbl_pos  [fhtsp_pkg::SLOT_COUNT];

    plan_t planned_results [$];
    int    mismatch_count = 0;
    int    cycle_count    = 0;
    bit    send_gap_on    = 1'b0;
    bit    recv_gap_on    = 1'b0;
    int    stall_request  = 0;

    file_handle_table_sector_planner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .handle       (handle),
        .file_found   (file_found),
        .open_mode    (open_mode),
        .file_length  (file_length),
        .start_lba    (start_lba),
        .seek_offset  (seek_offset),
        .seek_origin  (seek_origin),
        .read_length  (read_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value        (value),
        .head_sector  (head_sector),
        .head_offset  (head_offset),
        .head_bytes   (head_bytes),
        .body_sector  (body_sector),
        .body_sectors (body_sectors),
        .tail_sector  (tail_sector),
        .tail_bytes   (tail_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic plan_t plan_request(request_t r);
        plan_t                          res;
        int                             h;
        int                             i;
        int                             slot;
        longint                         target;
        longint                         size;
        logic [fhtsp_pkg::BYTE_W-1:0]   len;
        logic [fhtsp_pkg::BYTE_W-1:0]   pos;
        logic [fhtsp_pkg::BYTE_W-1:0]   grant;
        logic [fhtsp_pkg::BYTE_W-1:0]   rest;
        logic [11:0]                    hbytes;
        logic [fhtsp_pkg::OFFSET_W-1:0] hoff;
        logic [fhtsp_pkg::SECTOR_W-1:0] hsec;
        logic [fhtsp_pkg::SECTOR_W-1:0] bsec;
        res = '0;
        h = int'(r.handle);
        if (r.action == fhtsp_pkg::ACT_OPEN)
        begin
            if (!r.found)
                res.status = fhtsp_pkg::ST_NOT_FOUND;
            else if (r.mode != fhtsp_pkg::MODE_READ_ONLY)
                res.status = fhtsp_pkg::ST_BAD_MODE;
            else
            begin
                slot = -1;
                for (i = fhtsp_pkg::SLOT_COUNT - 1; i >= 0; i--)
                    if (!tbl_used[i])
                        slot = i;
                if (slot < 0)
                    res.status = fhtsp_pkg::ST_FULL;
                else
                begin
                    tbl_used[slot] = 1'b1;
                    tbl_len[slot]  = r.length;
                    tbl_lba[slot]  = r.lba;
                    tbl_pos[slot]  = '0;
                    res.status     = fhtsp_pkg::ST_OK;
                    res.value      = fhtsp_pkg::BYTE_W'(slot);
                end
            end
        end
        else if (h >= fhtsp_pkg::SLOT_COUNT || !tbl_used[h])
            res.status = fhtsp_pkg::ST_NOT_OPEN;
        else if (r.action == fhtsp_pkg::ACT_SEEK)
        begin
            size = longint'(tbl_len[h]);
            if (r.origin == fhtsp_pkg::ORG_BAD)
                res.status = fhtsp_pkg::ST_BAD_ORIGIN;
            else
            begin
                if (r.origin == fhtsp_pkg::ORG_SET)
                    target = longint'($signed(r.offset));
                else if (r.origin == fhtsp_pkg::ORG_CUR)
                    target = longint'(tbl_pos[h]) + longint'($signed(r.offset));
                else
                    target = size + longint'($signed(r.offset));
                if (target < 0)
                    target = 0;
                if (target > size)
                    target = size;
                tbl_pos[h] = fhtsp_pkg::BYTE_W'(target);
                res.status = fhtsp_pkg::ST_OK;
                res.value  = fhtsp_pkg::BYTE_W'(target);
            end
        end
        else if (r.action == fhtsp_pkg::ACT_READ)
        begin
            len   = tbl_len[h];
            pos   = tbl_pos[h];
            grant = (pos > len) ? '0 : len - pos;
            if (r.read_len < grant)
                grant = r.read_len;
            hsec   = fhtsp_pkg::SECTOR_W'(tbl_lba[h])
                     + fhtsp_pkg::SECTOR_W'(pos >> SECTOR_SHIFT);
            hoff   = pos[fhtsp_pkg::OFFSET_W-1:0];
            rest   = grant;
            bsec   = hsec;
            hbytes = '0;
            if (hoff != '0)
            begin
                hbytes = fhtsp_pkg::SECTOR_BYTES - {1'b0, hoff};
                if (rest < fhtsp_pkg::BYTE_W'(hbytes))
                    hbytes = rest[11:0];
                rest = rest - fhtsp_pkg::BYTE_W'(hbytes);
                bsec = hsec + 32'd1;
            end
            res.status       = fhtsp_pkg::ST_OK;
            res.value        = grant;
            res.head_sector  = hsec;
            res.head_offset  = hoff;
            res.head_bytes   = hbytes[fhtsp_pkg::OFFSET_W-1:0];
            res.body_sector  = bsec;
            res.body_sectors = fhtsp_pkg::COUNT_W'(rest >> SECTOR_SHIFT);
            res.tail_sector  = bsec + fhtsp_pkg::SECTOR_W'(rest >> SECTOR_SHIFT);
            res.tail_bytes   = rest[fhtsp_pkg::OFFSET_W-1:0];
            tbl_pos[h]       = pos + grant;
        end
        else
        begin
            tbl_used[h] = 1'b0;
            res.status  = fhtsp_pkg::ST_OK;
        end
        return res;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        plan_t    want;
        request_t req;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (planned_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with no request pending, %s %0d",
                             $time, "expected none, actual status", status);
                end
                else
                begin
                    want = planned_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("value", 32'(want.value), 32'(value));
                    compare_field("head_sector", want.head_sector, head_sector);
                    compare_field("head_offset", 32'(want.head_offset), 32'(head_offset));
                    compare_field("head_bytes", 32'(want.head_bytes), 32'(head_bytes));
                    compare_field("body_sector", want.body_sector, body_sector);
                    compare_field("body_sectors", 32'(want.body_sectors), 32'(body_sectors));
                    compare_field("tail_sector", want.tail_sector, tail_sector);
                    compare_field("tail_bytes", 32'(want.tail_bytes), 32'(tail_bytes));
                end
            end
            if (in_valid && in_ready)
            begin
                req.action   = action;
                req.handle   = handle;
                req.found    = file_found;
                req.mode     = open_mode;
                req.length   = file_length;
                req.lba      = start_lba;
                req.offset   = seek_offset;
                req.origin   = seek_origin;
                req.read_len = read_length;
                planned_results.push_back(plan_request(req));
            end
        end
    end

    // The receiver takes a long hold when asked, right after its next beat.
    initial
    begin
        int gap;
        int hold;
        wait (rst_n);
        forever
        begin
            if (stall_request > 0)
            begin
                hold = stall_request;
                stall_request = 0;
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            gap = recv_gap_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic send_req(request_t r);
        int gap;
        gap = send_gap_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= r.action;
        handle      <= r.handle;
        file_found  <= r.found;
        open_mode   <= r.mode;
        file_length <= r.length;
        start_lba   <= r.lba;
        seek_offset <= r.offset;
        seek_origin <= r.origin;
        read_length <= r.read_len;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (planned_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic request_t rand_request();
        request_t r;
        r.action   = 2'($urandom_range(0, 3));
        r.handle   = fhtsp_pkg::HANDLE_W'($urandom_range(0, 63));
        r.found    = 1'($urandom_range(0, 1));
        r.mode     = 4'($urandom_range(0, 15));
        r.length   = fhtsp_pkg::BYTE_W'($urandom());
        r.lba      = fhtsp_pkg::BYTE_W'($urandom());
        r.offset   = $urandom();
        r.origin   = 2'($urandom_range(0, 3));
        r.read_len = fhtsp_pkg::BYTE_W'($urandom());
        return r;
    endfunction

    function automatic request_t make_open(logic found, logic [3:0] mode,
                                           logic [fhtsp_pkg::BYTE_W-1:0] len,
                                           logic [fhtsp_pkg::BYTE_W-1:0] lba);
        request_t r;
        r        = rand_request();
        r.action = fhtsp_pkg::ACT_OPEN;
        r.found  = found;
        r.mode   = mode;
        r.length = len;
        r.lba    = lba;
        return r;
    endfunction

    function automatic request_t make_seek(int h, logic signed [31:0] off, logic [1:0] origin);
        request_t r;
        r        = rand_request();
        r.action = fhtsp_pkg::ACT_SEEK;
        r.handle = fhtsp_pkg::HANDLE_W'(h);
        r.offset = off;
        r.origin = origin;
        return r;
    endfunction

    function automatic request_t make_read(int h, logic [fhtsp_pkg::BYTE_W-1:0] n);
        request_t r;
        r          = rand_request();
        r.action   = fhtsp_pkg::ACT_READ;
        r.handle   = fhtsp_pkg::HANDLE_W'(h);
        r.read_len = n;
        return r;
    endfunction

    function automatic request_t make_close(int h);
        request_t r;
        r        = rand_request();
        r.action = fhtsp_pkg::ACT_CLOSE;
        r.handle = fhtsp_pkg::HANDLE_W'(h);
        return r;
    endfunction

    function automatic int count_open();
        int i;
        int n;
        n = 0;
        for (i = 0; i < fhtsp_pkg::SLOT_COUNT; i++)
            if (tbl_used[i])
                n++;
        return n;
    endfunction

    function automatic int pick_open_handle();
        int list [$];
        int i;
        for (i = 0; i < fhtsp_pkg::SLOT_COUNT; i++)
            if (tbl_used[i])
                list.push_back(i);
        if (list.size() == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return list[$urandom_range(0, list.size() - 1)];
    endfunction

    task automatic test_open_checks();
        send_req(make_open(1'b0, 4'd0, 31'd500, 31'd10));
        send_req(make_open(1'b1, 4'd0, 31'd500, 31'd10));
        send_req(make_open(1'b1, 4'd15, 31'd500, 31'd10));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd0, 31'd0));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd10000, 31'd100));
        wait_drain();
    endtask

    task automatic test_not_open();
        send_req(make_seek(63, 32'sd10, fhtsp_pkg::ORG_SET));
        send_req(make_read(16, 31'd100));
        send_req(make_read(15, 31'd100));
        send_req(make_close(3));
        wait_drain();
    endtask

    task automatic test_seek();
        send_req(make_seek(2, 32'sd5000, fhtsp_pkg::ORG_SET));
        send_req(make_seek(2, -32'sd6000, fhtsp_pkg::ORG_CUR));
        send_req(make_seek(2, 32'sh7FFF_FFFF, fhtsp_pkg::ORG_CUR));
        send_req(make_seek(2, -32'sd1, fhtsp_pkg::ORG_END));
        send_req(make_seek(2, 32'sd5, fhtsp_pkg::ORG_END));
        send_req(make_seek(2, 32'sh8000_0000, fhtsp_pkg::ORG_SET));
        send_req(make_seek(2, 32'sd20, fhtsp_pkg::ORG_BAD));
        send_req(make_seek(0, 32'sh7FFF_FFFF, fhtsp_pkg::ORG_SET));
        wait_drain();
    endtask

    task automatic test_read();
        send_req(make_seek(2, 32'sd0, fhtsp_pkg::ORG_SET));
        send_req(make_read(2, 31'd4096));
        send_req(make_read(2, 31'd0));
        send_req(make_seek(2, 32'sd3000, fhtsp_pkg::ORG_SET));
        send_req(make_read(2, 31'd100));
        send_req(make_read(2, 31'd7000));
        send_req(make_read(2, 31'd50));
        send_req(make_seek(0, 32'sd0, fhtsp_pkg::ORG_SET));
        send_req(make_read(0, 31'h7FFF_FFFF));
        send_req(make_read(1, 31'd10));
        send_req(make_close(0));
        send_req(make_close(1));
        send_req(make_close(2));
        wait_drain();
    endtask

    task automatic test_table_full();
        int i;
        send_gap_on = 1'b1;
        recv_gap_on = 1'b1;
        for (i = 0; i <= fhtsp_pkg::SLOT_COUNT; i++)
            send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY,
                               fhtsp_pkg::BYTE_W'($urandom_range(0, 50000)),
                               fhtsp_pkg::BYTE_W'($urandom_range(0, 5000))));
        send_req(make_close(5));
        send_req(make_close(9));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd4096, 31'd8));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd2048, 31'd9));
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd1, 31'd1));
        for (i = 0; i < fhtsp_pkg::SLOT_COUNT; i++)
            send_req(make_close(i));
        wait_drain();
    endtask

    task automatic test_output_stall();
        int k;
        send_gap_on = 1'b0;
        recv_gap_on = 1'b0;
        send_req(make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, 31'd100000, 31'd77));
        stall_request = 300;
        for (k = 0; k < 16; k++)
            if (k % 2 == 0)
                send_req(make_seek(0, 32'($urandom_range(0, 20000)) - 32'sd10000,
                                   fhtsp_pkg::ORG_CUR));
            else
                send_req(make_read(0, fhtsp_pkg::BYTE_W'($urandom_range(0, 9000))));
        send_req(make_close(0));
        wait_drain();
    endtask

    function automatic logic signed [31:0] rand_offset();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 6000)) - 32'sd3000;
            1: return 32'sd2048 * (32'($urandom_range(0, 40)) - 32'sd20);
            2: return $urandom();
            3: return ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'($urandom_range(0, 100000)) - 32'sd50000;
        endcase
    endfunction

    function automatic logic [fhtsp_pkg::BYTE_W-1:0] rand_read_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return fhtsp_pkg::BYTE_W'($urandom_range(0, 5000));
        else if (pick < 80)
            return fhtsp_pkg::BYTE_W'($urandom_range(0, 200000));
        else if (pick < 90)
            return fhtsp_pkg::BYTE_W'($urandom());
        else if (pick < 95)
            return '0;
        return fhtsp_pkg::BYTE_W'(2048 * $urandom_range(1, 8));
    endfunction

    function automatic logic [fhtsp_pkg::BYTE_W-1:0] rand_file_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return fhtsp_pkg::BYTE_W'($urandom_range(0, 20000));
        else if (pick < 85)
            return fhtsp_pkg::BYTE_W'($urandom_range(0, 1 << 22));
        else if (pick < 95)
            return fhtsp_pkg::BYTE_W'($urandom());
        return '0;
    endfunction

    task automatic test_random();
        int       n;
        int       pick;
        int       open_now;
        request_t req;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                send_gap_on = ($urandom_range(0, 3) != 0);
                recv_gap_on = ($urandom_range(0, 3) != 0);
            end
            open_now = count_open();
            pick = $urandom_range(0, 99);
            if (pick < 8)
                req = rand_request();
            else if (pick < 22 || open_now == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    req = make_open(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                    rand_file_len(), fhtsp_pkg::BYTE_W'($urandom()));
                else
                    req = make_open(1'b1, fhtsp_pkg::MODE_READ_ONLY, rand_file_len(),
                                    ($urandom_range(0, 1) == 1)
                                        ? fhtsp_pkg::BYTE_W'($urandom())
                                        : fhtsp_pkg::BYTE_W'($urandom_range(0, 1000)));
            end
            else if (pick < 26 + open_now)
                req = make_close(pick_open_handle());
            else if (pick < 62)
                req = make_seek(pick_open_handle(), rand_offset(),
                                ($urandom_range(0, 9) == 0) ? fhtsp_pkg::ORG_BAD
                                                            : 2'($urandom_range(0, 2)));
            else
                req = make_read(pick_open_handle(), rand_read_len());
            send_req(req);
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_open_checks();
        test_not_open();
        test_seek();
        test_read();
        test_table_full();
        test_output_stall();
        test_random();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
